/* src/rla_pkg.sv */
// Shared constants, types and codes for the receive line assembler.
// Used by rla_line_ram, rla_seq and rx_line_assembler.
package rla_pkg;

	localparam int LINE_CAPACITY = 64;
	localparam int IDX_W = $clog2(LINE_CAPACITY);
	localparam int ADDR_W = IDX_W + 1;

	localparam logic [IDX_W-1:0] LEN_MAX = IDX_W'(LINE_CAPACITY - 1);

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	typedef enum logic [2:0] {
		EV_ABSORBED = 3'd0,
		EV_STORED   = 3'd1,
		EV_BUSY     = 3'd2,
		EV_TOO_LONG = 3'd3,
		EV_CHAR     = 3'd4,
		EV_REFUSED  = 3'd5
	} ev_t;

	typedef struct packed {
		ev_t        ev;
		logic [7:0] ch;
		logic       last;
	} res_t;

	typedef struct packed {
		logic              we;
		logic              re;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        wdata;
	} ram_req_t;

endpackage

/* src/rla_line_ram.sv */
// Line store: two line banks in one synchronous memory with a registered read port.
// Depends on rla_pkg for the address width and request struct.
module rla_line_ram (
	input  logic               clk,
	input  rla_pkg::ram_req_t  req,
	output logic [7:0]         rdata
);

	logic [7:0] mem [2**rla_pkg::ADDR_W];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.addr];
		end
	end

endmodule

/* src/rla_seq.sv */
// Sequencer: line assembly, holder bookkeeping and read-out of the held line.
// Depends on rla_pkg; drives rla_line_ram through a request struct.
module rla_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rx_valid,
	output logic                rx_stall,
	input  logic                mode,
	input  logic [7:0]          data_byte,
	input  logic [7:0]          max_length,
	output logic                res_push,
	output rla_pkg::res_t       res,
	input  logic                res_ready,
	output rla_pkg::ram_req_t   ram_req,
	input  logic [7:0]          ram_rdata
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_FETCH = 4'b0010,
		ST_EMIT  = 4'b0100,
		ST_TERM  = 4'b1000
	} state_t;

	localparam int IW = rla_pkg::IDX_W;

	state_t        state_q, state_d;
	logic [IW-1:0] work_len_q, work_len_d;
	logic [IW-1:0] held_len_q, held_len_d;
	logic [IW-1:0] idx_q, idx_d;
	logic [IW-1:0] limit_q, limit_d;
	logic          work_bank_q, work_bank_d;
	logic          held_bank_q, held_bank_d;
	logic          held_valid_q, held_valid_d;
	logic          discard_q, discard_d;
	logic          accept;
	logic [8:0]    ml_m1;
	logic [IW-1:0] limit_calc;
	logic [IW-1:0] idx_inc;

	assign rx_stall = !(state_q == ST_IDLE && res_ready);
	assign accept = rx_valid && !rx_stall;
	assign ml_m1 = {1'b0, max_length} - 9'd1;
	assign limit_calc = (ml_m1 > 9'(held_len_q)) ? held_len_q : ml_m1[IW-1:0];
	assign idx_inc = idx_q + IW'(1);

	always_comb begin
		state_d = state_q;
		work_len_d = work_len_q;
		held_len_d = held_len_q;
		idx_d = idx_q;
		limit_d = limit_q;
		work_bank_d = work_bank_q;
		held_bank_d = held_bank_q;
		held_valid_d = held_valid_q;
		discard_d = discard_q;
		res_push = 1'b0;
		res.ev = rla_pkg::EV_ABSORBED;
		res.ch = 8'd0;
		res.last = 1'b1;
		ram_req.we = 1'b0;
		ram_req.re = 1'b0;
		ram_req.addr = {work_bank_q, work_len_q};
		ram_req.wdata = data_byte;

		unique case (state_q)
			ST_IDLE: begin
				if (accept && !mode) begin
					res_push = 1'b1;
					if (data_byte == rla_pkg::CH_CR) begin
						res.ev = rla_pkg::EV_ABSORBED;
					end else if (data_byte == rla_pkg::CH_LF) begin
						if (discard_q) begin
							discard_d = 1'b0;
							work_len_d = '0;
						end else if (work_len_q == '0) begin
							res.ev = rla_pkg::EV_ABSORBED;
						end else if (held_valid_q) begin
							work_len_d = '0;
							res.ev = rla_pkg::EV_BUSY;
						end else begin
							held_bank_d = work_bank_q;
							work_bank_d = !work_bank_q;
							held_len_d = work_len_q;
							held_valid_d = 1'b1;
							work_len_d = '0;
							res.ev = rla_pkg::EV_STORED;
						end
					end else if (discard_q) begin
						res.ev = rla_pkg::EV_ABSORBED;
					end else if (work_len_q < rla_pkg::LEN_MAX) begin
						ram_req.we = 1'b1;
						work_len_d = work_len_q + IW'(1);
					end else begin
						work_len_d = '0;
						discard_d = 1'b1;
						res.ev = rla_pkg::EV_TOO_LONG;
					end
				end else if (accept) begin
					if (max_length == 8'd0 || !held_valid_q) begin
						res_push = 1'b1;
						res.ev = rla_pkg::EV_REFUSED;
					end else begin
						limit_d = limit_calc;
						idx_d = '0;
						state_d = ST_FETCH;
					end
				end
			end
			ST_FETCH: begin
				if (idx_q < limit_q) begin
					ram_req.re = 1'b1;
					ram_req.addr = {held_bank_q, idx_q};
					state_d = ST_EMIT;
				end else begin
					state_d = ST_TERM;
				end
			end
			ST_EMIT: begin
				if (ram_rdata == 8'd0) begin
					state_d = ST_TERM;
				end else if (res_ready) begin
					res_push = 1'b1;
					res.ev = rla_pkg::EV_CHAR;
					res.ch = ram_rdata;
					res.last = 1'b0;
					idx_d = idx_inc;
					if (idx_inc < limit_q) begin
						ram_req.re = 1'b1;
						ram_req.addr = {held_bank_q, idx_inc};
					end else begin
						state_d = ST_TERM;
					end
				end
			end
			ST_TERM: begin
				if (res_ready) begin
					res_push = 1'b1;
					res.ev = rla_pkg::EV_CHAR;
					held_valid_d = 1'b0;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			work_len_q <= '0;
			held_len_q <= '0;
			idx_q <= '0;
			limit_q <= '0;
			work_bank_q <= 1'b0;
			held_bank_q <= 1'b1;
			held_valid_q <= 1'b0;
			discard_q <= 1'b0;
		end else begin
			state_q <= state_d;
			work_len_q <= work_len_d;
			held_len_q <= held_len_d;
			idx_q <= idx_d;
			limit_q <= limit_d;
			work_bank_q <= work_bank_d;
			held_bank_q <= held_bank_d;
			held_valid_q <= held_valid_d;
			discard_q <= discard_d;
		end
	end

endmodule

/* src/rx_line_assembler.sv */
// Top level of the receive line assembler: sequencer, line store, output register.
// Depends on rla_pkg, rla_line_ram and rla_seq.
//
//  channel | valid    | stall    | payload
//  rx      | rx_valid | rx_stall | mode, data_byte, max_length
//  res     | res_valid| res_stall| event_res, line_char, last
//
// A received byte with mode low gives one result beat.
// A read is accepted, then the first character of the held line is fetched, then
// characters stream at one beat a cycle while the result side is ready, then the
// terminator beat follows; a stored zero byte ends the line early and is not emitted.
// A newline that stores a line swaps the two line banks in the memory, so no copy is made.
// Reset clears all control state; memory contents stay undefined.
// A stalled result holds in the output register; rx stalls while one waits.
module rx_line_assembler (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic       mode,
	input  logic [7:0] data_byte,
	input  logic [7:0] max_length,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [2:0] event_res,
	output logic [7:0] line_char,
	output logic       last
);

	rla_pkg::ram_req_t ram_req;
	rla_pkg::res_t     res;
	logic [7:0]        ram_rdata;
	logic              res_push;
	logic              res_ready;
	logic              out_valid_q;
	rla_pkg::res_t     out_q;

	assign res_ready = !out_valid_q || !res_stall;

	rla_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_stall  (rx_stall),
		.mode      (mode),
		.data_byte (data_byte),
		.max_length(max_length),
		.res_push  (res_push),
		.res       (res),
		.res_ready (res_ready),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	rla_line_ram u_ram (
		.clk  (clk),
		.req  (ram_req),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_push;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_push) begin
			out_q <= res;
		end
	end

	assign res_valid = out_valid_q;
	assign event_res = out_q.ev;
	assign line_char = out_q.ch;
	assign last = out_q.last;

endmodule
